@@ design/jsu_pkg.sv @@
package jsu_pkg;

   // one raw byte of the string body
   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_text;
   } req_type;

   // one decoded result
   typedef struct packed {
      logic [7:0] out_byte;
      logic [1:0] kind;
      logic [2:0] error_code;
      logic       last_of_run;
   } rsp_type;

   localparam logic [1:0] KIND_BYTE  = 2'd0;
   localparam logic [1:0] KIND_CLOSE = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   localparam logic [2:0] ERR_NONE     = 3'd0;
   localparam logic [2:0] ERR_ILLEGAL  = 3'd1;
   localparam logic [2:0] ERR_BAD_HEX  = 3'd2;
   localparam logic [2:0] ERR_ESC_CUT  = 3'd3;
   localparam logic [2:0] ERR_UNI_CUT  = 3'd4;
   localparam logic [2:0] ERR_UNCLOSED = 3'd5;

   // all results caused by one input byte, bytes[0] goes out first
   typedef struct packed {
      logic [1:0]      count;
      logic [2:0][7:0] bytes;
      logic [1:0]      kind;
      logic [2:0]      error_code;
   } bundle_type;

endpackage

@@ design/jsu_decode.sv @@
module jsu_decode import jsu_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  req_type    item,
   input  logic       advance,
   output bundle_type bundle
);

   localparam logic [2:0] MODE_PLAIN = 3'd0;
   localparam logic [2:0] MODE_ESC   = 3'd1;
   localparam logic [2:0] MODE_HEX   = 3'd2;
   localparam logic [2:0] MODE_ENDED = 3'd3;

   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_B      = 8'h62;
   localparam logic [7:0] CH_F      = 8'h66;
   localparam logic [7:0] CH_N      = 8'h6E;
   localparam logic [7:0] CH_R      = 8'h72;
   localparam logic [7:0] CH_T      = 8'h74;
   localparam logic [7:0] CH_U      = 8'h75;

   localparam logic [7:0] CTL_BS  = 8'h08;
   localparam logic [7:0] CTL_FF  = 8'h0C;
   localparam logic [7:0] CTL_LF  = 8'h0A;
   localparam logic [7:0] CTL_CR  = 8'h0D;
   localparam logic [7:0] CTL_TAB = 8'h09;

   localparam logic [15:0] LIMIT_1B  = 16'h0080;
   localparam logic [15:0] LIMIT_2B  = 16'h0800;
   localparam logic [7:0]  LEAD_2B   = 8'hC0;
   localparam logic [7:0]  LEAD_3B   = 8'hE0;
   localparam logic [7:0]  CONT_BYTE = 8'h80;
   localparam logic [7:0]  CONT_MASK = 8'h3F;
   localparam logic [2:0]  HEX_DIGITS = 3'd4;

   logic [2:0]  mode_ff, mode_in;
   logic [15:0] cp_ff, cp_in;
   logic [2:0]  hc_ff, hc_in;

   logic [4:0]  digit;
   logic [15:0] cp_next;
   logic [2:0]  hc_next;
   logic        do_emit, do_fail;
   logic [7:0]  emit_val;
   logic [2:0]  fail_code;

   // bit 4 flags a legal hex digit, low nibble is its value
   function automatic logic [4:0] hex_value(input logic [7:0] b);
      logic [4:0] r;
      r = '0;
      if (b inside {[8'h30:8'h39]}) begin
         r = {1'b1, b[3:0]};
      end else if (b inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
         r = {1'b1, b[3:0] + 4'd9};
      end
      return r;
   endfunction

   assign digit   = hex_value(item.data_byte);
   assign cp_next = {cp_ff[11:0], digit[3:0]};
   assign hc_next = hc_ff + 3'd1;

   always_comb begin
      mode_in   = mode_ff;
      cp_in     = cp_ff;
      hc_in     = hc_ff;
      bundle    = '0;
      do_emit   = 1'b0;
      do_fail   = 1'b0;
      emit_val  = '0;
      fail_code = ERR_NONE;
      case (mode_ff)
         MODE_PLAIN: begin
            if (item.data_byte == CH_QUOTE) begin
               bundle.count = 2'd1;
               bundle.kind  = KIND_CLOSE;
               mode_in      = MODE_ENDED;
            end else if (item.data_byte == CH_BSLASH) begin
               if (item.end_of_text) begin
                  do_fail   = 1'b1;
                  fail_code = ERR_ESC_CUT;
               end else begin
                  mode_in = MODE_ESC;
               end
            end else begin
               do_emit  = 1'b1;
               emit_val = item.data_byte;
            end
         end
         MODE_ESC: begin
            do_emit = 1'b1;
            case (item.data_byte)
               CH_QUOTE:  emit_val = CH_QUOTE;
               CH_BSLASH: emit_val = CH_BSLASH;
               CH_SLASH:  emit_val = CH_SLASH;
               CH_B:      emit_val = CTL_BS;
               CH_F:      emit_val = CTL_FF;
               CH_N:      emit_val = CTL_LF;
               CH_R:      emit_val = CTL_CR;
               CH_T:      emit_val = CTL_TAB;
               CH_U: begin
                  do_emit = 1'b0;
                  if (item.end_of_text) begin
                     do_fail   = 1'b1;
                     fail_code = ERR_UNI_CUT;
                  end else begin
                     mode_in = MODE_HEX;
                     cp_in   = '0;
                     hc_in   = '0;
                  end
               end
               default: begin
                  do_emit   = 1'b0;
                  do_fail   = 1'b1;
                  fail_code = ERR_ILLEGAL;
               end
            endcase
         end
         MODE_HEX: begin
            if (!digit[4]) begin
               do_fail   = 1'b1;
               fail_code = ERR_BAD_HEX;
            end else begin
               cp_in = cp_next;
               hc_in = hc_next;
               if (hc_next < HEX_DIGITS) begin
                  if (item.end_of_text) begin
                     do_fail   = 1'b1;
                     fail_code = ERR_UNI_CUT;
                  end
               end else begin
                  hc_in = '0;
                  if (item.end_of_text) begin
                     do_fail   = 1'b1;
                     fail_code = ERR_UNCLOSED;
                  end else begin
                     mode_in = MODE_PLAIN;
                     if (cp_next < LIMIT_1B) begin
                        bundle.count    = 2'd1;
                        bundle.bytes[0] = cp_next[7:0];
                     end else if (cp_next < LIMIT_2B) begin
                        bundle.count    = 2'd2;
                        bundle.bytes[0] = LEAD_2B | {3'b000, cp_next[10:6]};
                        bundle.bytes[1] = CONT_BYTE | (cp_next[7:0] & CONT_MASK);
                     end else begin
                        bundle.count    = 2'd3;
                        bundle.bytes[0] = LEAD_3B | {4'b0000, cp_next[15:12]};
                        bundle.bytes[1] = CONT_BYTE | (cp_next[13:6] & CONT_MASK);
                        bundle.bytes[2] = CONT_BYTE | (cp_next[7:0] & CONT_MASK);
                     end
                  end
               end
            end
         end
         default: begin
            mode_in = MODE_ENDED;
         end
      endcase

      // a decoded byte on the last byte of the text means no closing quote
      if (do_emit) begin
         if (item.end_of_text) begin
            do_fail   = 1'b1;
            fail_code = ERR_UNCLOSED;
         end else begin
            bundle.count    = 2'd1;
            bundle.bytes[0] = emit_val;
            mode_in         = MODE_PLAIN;
         end
      end

      if (do_fail) begin
         bundle            = '0;
         bundle.count      = 2'd1;
         bundle.kind       = KIND_ERROR;
         bundle.error_code = fail_code;
         mode_in           = MODE_ENDED;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_PLAIN;
         cp_ff   <= '0;
         hc_ff   <= '0;
      end else if (advance) begin
         mode_ff <= mode_in;
         cp_ff   <= cp_in;
         hc_ff   <= hc_in;
      end
   end

endmodule

@@ design/jsu_out_buf.sv @@
module jsu_out_buf import jsu_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  bundle_type bundle,
   input  logic       offer,
   output logic       load_ok,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data
);

   bundle_type hold_ff;
   logic [1:0] rem_ff;
   logic [1:0] idx_ff;
   logic       take;

   assign rsp_valid = (rem_ff != 2'd0);
   assign take      = rsp_valid && !rsp_stall;
   // free now, or the last result of the held group leaves this cycle
   assign load_ok   = (rem_ff == 2'd0) || (rem_ff == 2'd1 && !rsp_stall);

   assign rsp_data.out_byte    = hold_ff.bytes[idx_ff];
   assign rsp_data.kind        = hold_ff.kind;
   assign rsp_data.error_code  = hold_ff.error_code;
   assign rsp_data.last_of_run = (rem_ff == 2'd1);

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= '0;
         idx_ff <= '0;
      end else if (offer && load_ok) begin
         rem_ff <= bundle.count;
         idx_ff <= '0;
      end else if (take) begin
         rem_ff <= rem_ff - 2'd1;
         idx_ff <= idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (offer && load_ok) begin
         hold_ff <= bundle;
      end
   end

endmodule

@@ design/json_string_unescape.sv @@
// json_string_unescape: decodes the body of a JSON string, one raw byte per
// transaction on the req_ channel, starting just after the opening quote.
// req_data carries the byte and an end_of_text flag for the last byte of the
// text. Each transaction on the rsp_ channel carries one result: a decoded
// byte, a string-closed marker or an error with its code; last_of_run marks
// the final result caused by one input byte. A \u escape yields one to three
// UTF-8 bytes; after a close or an error every further byte yields nothing.
// The input register takes the req_ byte, then the decoder feeds the result
// register, which drives the rsp_ channel. Throughput is one byte per cycle
// while each byte gives at most one result and the receiver does not stall;
// a \u escape that gives two or three UTF-8 bytes holds the result register
// until all of them have gone out, and req_stall is raised while the input
// register waits behind it. When the receiver stalls, the held result stays
// put, an empty input register still takes one more byte, then req_stall
// rises. Synchronous active-high reset empties both registers and returns
// the decoder to plain content mode.
module json_string_unescape import jsu_pkg::*; (
   input  logic    clock,
   input  logic    reset,

   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,

   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   // input register
   req_type    in_ff;
   logic       in_valid_ff;

   bundle_type bundle;
   logic       load_ok;
   logic       consume;
   logic       req_take;

   // the held byte moves on when the result register can take its group
   assign consume   = in_valid_ff && load_ok;
   assign req_stall = in_valid_ff && !load_ok;
   assign req_take  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (consume) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_ff <= req_data;
      end
   end

   // escape and \u decoding, state advances once per consumed byte
   jsu_decode u_decode (
      .clock   (clock),
      .reset   (reset),
      .item    (in_ff),
      .advance (consume),
      .bundle  (bundle)
   );

   // result register, sends a group of up to three results in order
   jsu_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .bundle    (bundle),
      .offer     (consume),
      .load_ok   (load_ok),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // close and error markers are always the only result of their byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind != KIND_BYTE |-> rsp_data.last_of_run)
      else $error("close or error result not marked last");

   // an error code goes with an error result and nothing else
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_data.kind == KIND_ERROR) == (rsp_data.error_code != ERR_NONE)))
      else $error("error code does not match result kind");

   // once the string has ended no further result appears
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_data.kind != KIND_BYTE |=> !rsp_valid)
      else $error("result after string ended");

endmodule
